@@ hdl/swds_pkg.sv @@
// Shared types, constants and step tables of the spot weld dot sequencer.
`default_nettype none

package swds_pkg;

   // Field widths
   localparam int PosWidth   = 20;
   localparam int AlignWidth = 21;
   localparam int CoordWidth = 17;
   localparam int BitsWidth  = 5;
   localparam int WaitWidth  = 25;
   localparam int MilsWidth  = 26;
   localparam int MagWidth   = 25;
   localparam int DivWidth   = 32;
   localparam int MulWidth   = 32;
   localparam int RootWidth  = 26;
   localparam int RadWidth   = 2 * RootWidth;

   // Alignment offsets in Q8 mm, scale factors in mils per mm times 100
   localparam logic signed [AlignWidth-1:0] ALIGN_X = 21'sd3968;
   localparam logic signed [AlignWidth-1:0] ALIGN_Y = 21'sd1536;
   localparam logic [12:0] SCALE_X = 13'd4866;
   localparam logic [12:0] SCALE_Y = 13'd4926;

   // Divide by 100: multiply by ceil(2^37 / 100), keep bits from 37 up
   localparam int                  RecipShift = 37;
   localparam logic [MulWidth-1:0] RECIP_100  = 32'd1374389535;
   localparam logic [DivWidth-1:0] FLOOR_BIAS = 32'd99;

   localparam logic [4:0] ROOT_LAST_COUNT = 5'(RootWidth - 1);

   localparam logic [WaitWidth+1:0] SETTLE_BASE = 27'd400000;
   localparam logic [WaitWidth-1:0] WAIT_MAX    = 25'h1FFFFFF;

   // Register index of the configuration port
   localparam logic REG_SIMULATE = 1'b0;

   // Drive word bits
   localparam logic [BitsWidth-1:0] BIT_RELEASE = 5'd1;
   localparam logic [BitsWidth-1:0] BIT_DOWN    = 5'd2;
   localparam logic [BitsWidth-1:0] BIT_WELDER  = 5'd4;
   localparam logic [BitsWidth-1:0] BIT_EXTRA   = 5'd8;
   localparam logic [BitsWidth-1:0] BIT_GAS     = 5'd16;

   // Result steps of one dot
   typedef logic [2:0] step_type;
   localparam step_type STEP_MOVE  = 3'd0;
   localparam step_type STEP_DROP  = 3'd1;
   localparam step_type STEP_FORCE = 3'd2;
   localparam step_type STEP_WELD  = 3'd3;
   localparam step_type STEP_HOLD  = 3'd4;
   localparam step_type STEP_LIFT  = 3'd5;
   localparam step_type STEP_OFF   = 3'd6;

   typedef enum logic [2:0] {
      MUL_AX = 3'd0,
      MUL_AY = 3'd1,
      MUL_RX = 3'd2,
      MUL_RY = 3'd3,
      MUL_DX = 3'd4,
      MUL_DY = 3'd5
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        fix;
      logic        diff;
      logic        root_init;
      logic        root_step;
      logic        settle;
      step_type    step;
   } cmd_type;

   typedef struct packed {
      logic                  is_move;
      logic [CoordWidth-1:0] move_x;
      logic [CoordWidth-1:0] move_y;
      logic [BitsWidth-1:0]  drive_bits;
      logic [WaitWidth-1:0]  wait_us;
      logic                  last;
   } result_type;

   function automatic logic [BitsWidth-1:0] step_bits(input step_type step,
                                                      input logic extra,
                                                      input logic sim);
      logic [BitsWidth-1:0] gas;
      logic [BitsWidth-1:0] weld;
      logic [BitsWidth-1:0] ep;
      logic [BitsWidth-1:0] bits;
      gas  = sim ? '0 : BIT_GAS;
      weld = sim ? '0 : BIT_WELDER;
      ep   = extra ? BIT_EXTRA : '0;
      unique case (step)
         STEP_DROP:  bits = BIT_RELEASE | gas;
         STEP_FORCE: bits = BIT_RELEASE | BIT_DOWN | gas | ep;
         STEP_WELD:  bits = BIT_RELEASE | BIT_DOWN | gas | weld | ep;
         STEP_HOLD:  bits = BIT_RELEASE | BIT_DOWN | gas;
         STEP_LIFT:  bits = gas;
         default:    bits = '0;
      endcase
      return bits;
   endfunction

   function automatic logic [WaitWidth-1:0] step_wait(input step_type step);
      logic [WaitWidth-1:0] w;
      unique case (step)
         STEP_DROP:  w = 25'd400000;
         STEP_FORCE: w = 25'd300000;
         STEP_WELD:  w = 25'd500000;
         STEP_HOLD:  w = 25'd300000;
         STEP_LIFT:  w = 25'd300000;
         STEP_OFF:   w = 25'd3000000;
         default:    w = '0;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

@@ hdl/swds_if.sv @@
// Valid/ready channel interfaces for weld dots and sequencer results.
`default_nettype none

interface swds_req_if;
   logic               valid;
   logic               ready;
   logic signed [19:0] target_x;
   logic signed [19:0] target_y;
   logic               power_boost;

   modport source(output valid, target_x, target_y, power_boost, input ready);
   modport sink(input valid, target_x, target_y, power_boost, output ready);
endinterface

interface swds_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_move;
   logic [16:0] move_x;
   logic [16:0] move_y;
   logic [4:0]  drive_bits;
   logic [24:0] wait_us;
   logic        last;

   modport source(output valid, is_move, move_x, move_y, drive_bits, wait_us, last,
                  input ready);
   modport sink(input valid, is_move, move_x, move_y, drive_bits, wait_us, last,
                output ready);
endinterface

`default_nettype wire

@@ hdl/spot_weld_dot_sequencer_top.sv @@
// Top level of the spot weld dot sequencer.
//
// req_chan takes one weld dot per transfer: target x and y in signed Q8 mm and
// the extra power flag. For each dot the block gives seven transfers on
// rsp_chan: first the move with x and y in table mils and a settle wait that
// grows with the distance from the previous dot, then six drive words (drop,
// force, weld, hold, lift, all off) each with its wait; last marks the off step.
// The move result is ready only after these steps in order: two scaling
// multiplies, two reciprocal multiplies for the divide by 100, sign fix,
// difference, two squaring passes, root load, 26 bit-pair square root steps and
// the wait add, all products on one shared 32 by 32 multiplier. The square root
// steps make up most of the arithmetic. Only one dot is in flight: req_chan.ready
// is high while the block is idle. A stalled receiver holds the current result
// on rsp_chan and the sequence waits. Reset clears the previous position to the
// origin and the simulate bit to 0. The simulate bit (APB register at 0) clears
// the gas and welder bits; write it only while the block is idle.
`default_nettype none

module spot_weld_dot_sequencer_top
   import swds_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   swds_req_if.sink         req_chan,
   swds_rsp_if.source       rsp_chan,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);

   cmd_type    cmd;
   result_type result;
   logic       simulate;
   logic       req_ready;
   logic       rsp_valid;

   swds_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .simulate (simulate)
   );

   swds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   swds_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .simulate    (simulate),
      .target_x    (req_chan.target_x),
      .target_y    (req_chan.target_y),
      .power_boost (req_chan.power_boost),
      .result      (result)
   );

   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = rsp_valid;
   assign rsp_chan.is_move    = result.is_move;
   assign rsp_chan.move_x     = result.move_x;
   assign rsp_chan.move_y     = result.move_y;
   assign rsp_chan.drive_bits = result.drive_bits;
   assign rsp_chan.wait_us    = result.wait_us;
   assign rsp_chan.last       = result.last;

endmodule

`default_nettype wire

@@ hdl/swds_csr.sv @@
// Configuration register file: the simulate bit behind an APB-style port.
`default_nettype none

module swds_csr
   import swds_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready,
   output logic             simulate
);

   logic simulate_ff;
   logic simulate_in;
   logic wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_SIMULATE);

   assign simulate_in = wr_en ? pwdata[0] : simulate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         simulate_ff <= 1'b0;
      end else begin
         simulate_ff <= simulate_in;
      end
   end

   assign prdata   = (paddr[2] == REG_SIMULATE) ? {31'd0, simulate_ff} : 32'd0;
   assign simulate = simulate_ff;

endmodule

`default_nettype wire

@@ hdl/swds_dp.sv @@
// Datapath: alignment, mil scaling and reciprocal divide-by-100 on a shared multiplier,
// distance by integer square root, settle wait and result assembly.
`default_nettype none

module swds_dp
   import swds_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire cmd_type                     cmd,
   input  wire logic                        simulate,
   input  wire logic signed [PosWidth-1:0]  target_x,
   input  wire logic signed [PosWidth-1:0]  target_y,
   input  wire logic                        power_boost,
   output result_type                       result
);

   logic signed [AlignWidth-1:0] ax_ff, ay_ff;
   logic                         ep_ff;
   logic [DivWidth-1:0]          px_ff, py_ff;
   logic [MilsWidth-2:0]         qx_ff, qy_ff;
   logic                         negx_ff, negy_ff;
   logic signed [MilsWidth-1:0]  xq_ff, yq_ff;
   logic signed [MilsWidth-1:0]  lastx_ff, lasty_ff;
   logic [MagWidth-1:0]          dxa_ff, dya_ff;
   logic [2*MagWidth-1:0]        sqx_ff, sqy_ff;
   logic [RadWidth-1:0]          rad_ff;
   logic [RootWidth-1:0]         root_ff;
   logic [RootWidth:0]           rem_ff;
   logic [WaitWidth-1:0]         wait_ff;

   // Shared multiplier
   logic [AlignWidth-1:0] ax_neg, ay_neg;
   logic [AlignWidth-2:0] ax_mag, ay_mag;
   logic [MulWidth-1:0]   mul_a, mul_b;
   logic [2*MulWidth-1:0] product;

   assign ax_neg = -ax_ff;
   assign ay_neg = -ay_ff;
   assign ax_mag = ax_ff[AlignWidth-1] ? ax_neg[AlignWidth-2:0] : ax_ff[AlignWidth-2:0];
   assign ay_mag = ay_ff[AlignWidth-1] ? ay_neg[AlignWidth-2:0] : ay_ff[AlignWidth-2:0];

   always_comb begin
      unique case (cmd.mul_sel)
         MUL_AX: begin
            mul_a = MulWidth'(ax_mag);
            mul_b = MulWidth'(SCALE_X);
         end
         MUL_AY: begin
            mul_a = MulWidth'(ay_mag);
            mul_b = MulWidth'(SCALE_Y);
         end
         MUL_RX: begin
            mul_a = px_ff;
            mul_b = RECIP_100;
         end
         MUL_RY: begin
            mul_a = py_ff;
            mul_b = RECIP_100;
         end
         MUL_DX: begin
            mul_a = MulWidth'(dxa_ff);
            mul_b = MulWidth'(dxa_ff);
         end
         MUL_DY: begin
            mul_a = MulWidth'(dya_ff);
            mul_b = MulWidth'(dya_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product = mul_a * mul_b;

   // Bias negative magnitudes by 99 so the truncating divide rounds toward minus infinity
   logic [DivWidth-1:0] px_in, py_in;

   assign px_in = product[DivWidth-1:0] + (ax_ff[AlignWidth-1] ? FLOOR_BIAS : '0);
   assign py_in = product[DivWidth-1:0] + (ay_ff[AlignWidth-1] ? FLOOR_BIAS : '0);

   // Sign fix of the quotient magnitudes
   logic signed [MilsWidth-1:0] xq_in, yq_in;

   assign xq_in = negx_ff ? -$signed({1'b0, qx_ff}) : $signed({1'b0, qx_ff});
   assign yq_in = negy_ff ? -$signed({1'b0, qy_ff}) : $signed({1'b0, qy_ff});

   // Distance components
   logic signed [MilsWidth:0] dx, dy;
   logic [MilsWidth:0]        dx_mag, dy_mag;

   assign dx     = {xq_ff[MilsWidth-1], xq_ff} - {lastx_ff[MilsWidth-1], lastx_ff};
   assign dy     = {yq_ff[MilsWidth-1], yq_ff} - {lasty_ff[MilsWidth-1], lasty_ff};
   assign dx_mag = dx[MilsWidth] ? (MilsWidth+1)'(-dx) : dx;
   assign dy_mag = dy[MilsWidth] ? (MilsWidth+1)'(-dy) : dy;

   // One square root digit per step
   logic [RootWidth+2:0] root_cand, root_trial;
   logic                 root_bit;

   assign root_cand  = {rem_ff, rad_ff[RadWidth-1 -: 2]};
   assign root_trial = {1'b0, root_ff, 2'b01};
   assign root_bit   = root_cand >= root_trial;

   // Settle wait: base plus 130/256 of the distance, capped at WAIT_MAX
   logic [RootWidth+7:0]  scaled;
   logic [WaitWidth+1:0]  wait_sum;
   logic [WaitWidth-1:0]  wait_in;

   assign scaled   = ((RootWidth+8)'(root_ff) << 7) + ((RootWidth+8)'(root_ff) << 1);
   assign wait_sum = SETTLE_BASE + (WaitWidth+2)'(scaled[RootWidth+7:8]);
   assign wait_in  = (wait_sum > (WaitWidth+2)'(WAIT_MAX)) ? WAIT_MAX
                                                           : wait_sum[WaitWidth-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ax_ff <= AlignWidth'(target_x) + ALIGN_X;
         ay_ff <= AlignWidth'(target_y) + ALIGN_Y;
         ep_ff <= power_boost;
      end
      if (cmd.mul_en) begin
         unique case (cmd.mul_sel)
            MUL_AX: begin
               px_ff   <= px_in;
               negx_ff <= ax_ff[AlignWidth-1];
            end
            MUL_AY: begin
               py_ff   <= py_in;
               negy_ff <= ay_ff[AlignWidth-1];
            end
            MUL_RX: qx_ff  <= product[RecipShift +: MilsWidth-1];
            MUL_RY: qy_ff  <= product[RecipShift +: MilsWidth-1];
            MUL_DX: sqx_ff <= product[2*MagWidth-1:0];
            MUL_DY: sqy_ff <= product[2*MagWidth-1:0];
            default: begin
            end
         endcase
      end
      if (cmd.fix) begin
         xq_ff <= xq_in;
         yq_ff <= yq_in;
      end
      if (cmd.diff) begin
         dxa_ff <= dx_mag[MagWidth-1:0];
         dya_ff <= dy_mag[MagWidth-1:0];
      end
      if (cmd.root_init) begin
         rad_ff  <= RadWidth'({1'b0, sqx_ff} + {1'b0, sqy_ff});
         root_ff <= '0;
         rem_ff  <= '0;
      end else if (cmd.root_step) begin
         rad_ff  <= rad_ff << 2;
         root_ff <= {root_ff[RootWidth-2:0], root_bit};
         rem_ff  <= root_bit ? (RootWidth+1)'(root_cand - root_trial)
                             : root_cand[RootWidth:0];
      end
      if (cmd.settle) begin
         wait_ff <= wait_in;
      end
   end

   // Previous position survives between dots and resets to the origin
   always_ff @(posedge clock) begin
      if (reset) begin
         lastx_ff <= '0;
         lasty_ff <= '0;
      end else if (cmd.diff) begin
         lastx_ff <= xq_ff;
         lasty_ff <= yq_ff;
      end
   end

   always_comb begin
      result = '0;
      if (cmd.step == STEP_MOVE) begin
         result.is_move = 1'b1;
         result.move_x  = xq_ff[MilsWidth-1] ? '0 : xq_ff[MilsWidth-2:8];
         result.move_y  = yq_ff[MilsWidth-1] ? '0 : yq_ff[MilsWidth-2:8];
         result.wait_us = wait_ff;
      end else begin
         result.drive_bits = step_bits(cmd.step, ep_ff, simulate);
         result.wait_us    = step_wait(cmd.step);
         result.last       = (cmd.step == STEP_OFF);
      end
   end

endmodule

`default_nettype wire

@@ hdl/swds_ctrl.sv @@
// Controller: sequences the datapath through one dot and steps the seven results.
`default_nettype none

module swds_ctrl
   import swds_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output cmd_type   cmd
);

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0_0000_0000_0001,
      ST_MULX   = 13'b0_0000_0000_0010,
      ST_MULY   = 13'b0_0000_0000_0100,
      ST_RECX   = 13'b0_0000_0000_1000,
      ST_RECY   = 13'b0_0000_0001_0000,
      ST_FIX    = 13'b0_0000_0010_0000,
      ST_DIFF   = 13'b0_0000_0100_0000,
      ST_SQX    = 13'b0_0000_1000_0000,
      ST_SQY    = 13'b0_0001_0000_0000,
      ST_RINIT  = 13'b0_0010_0000_0000,
      ST_ROOT   = 13'b0_0100_0000_0000,
      ST_SETTLE = 13'b0_1000_0000_0000,
      ST_EMIT   = 13'b1_0000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   step_type   step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.mul_sel = MUL_AX;
      cmd.step    = step_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
            if (req_valid) begin
               state_in = ST_MULX;
            end
         end
         ST_MULX: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_AX;
            state_in    = ST_MULY;
         end
         ST_MULY: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_AY;
            state_in    = ST_RECX;
         end
         ST_RECX: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_RX;
            state_in    = ST_RECY;
         end
         ST_RECY: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_RY;
            state_in    = ST_FIX;
         end
         ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_SQX;
         end
         ST_SQX: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DX;
            state_in    = ST_SQY;
         end
         ST_SQY: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DY;
            state_in    = ST_RINIT;
         end
         ST_RINIT: begin
            cmd.root_init = 1'b1;
            cnt_in        = '0;
            state_in      = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            cnt_in        = cnt_ff + 5'd1;
            if (cnt_ff == ROOT_LAST_COUNT) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            cmd.settle = 1'b1;
            step_in    = STEP_MOVE;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            // advance one step per transfer, drop back to idle after the off step
            if (rsp_ready) begin
               if (step_ff == STEP_OFF) begin
                  step_in  = STEP_MOVE;
                  state_in = ST_IDLE;
               end else begin
                  step_in = step_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         step_ff  <= STEP_MOVE;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

@@ bench/spot_weld_dot_sequencer_top_tb.sv @@
// Self-checking bench for the spot weld dot sequencer: directed and random dots, APB setup, step checks.
`timescale 1ns / 100ps

module spot_weld_dot_sequencer_top_tb
   import swds_pkg::*;
();

   localparam int HALF_PERIOD  = 2;
   localparam int RESET_CYCLES = 11;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int TAIL_CYCLES  = 100;
   localparam int PHASE_DOTS   = 35;
   localparam int DIRECTED     = 12;

   localparam int POS_MIN  = -65536;
   localparam int POS_MAX  = 524287;
   localparam int POS_SPAN = POS_MAX - POS_MIN;

   localparam longint OFFSET_X_Q8    = 3968;
   localparam longint OFFSET_Y_Q8    = 1536;
   localparam longint MILS_X_CENTI   = 4866;
   localparam longint MILS_Y_CENTI   = 4926;
   localparam longint SETTLE_US      = 400000;
   localparam longint SETTLE_PER_MIL = 130;
   localparam longint COORD_LIMIT    = 131071;
   localparam longint HOLD_LIMIT     = 33554431;

   // Register map in byte addresses
   localparam logic [2:0] ADDR_SIMULATE = {REG_SIMULATE, 2'b00};
   localparam logic [2:0] ADDR_UNUSED   = 3'd4;

   logic        clock = 1'b0;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   swds_req_if req_chan ();
   swds_rsp_if rsp_chan ();

   spot_weld_dot_sequencer_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   class dot_step_board;
      result_type         steps_due[$];
      bit                 sim_on;
      logic signed [31:0] prev_x;
      logic signed [31:0] prev_y;
      int                 mismatches;

      function new();
         sim_on     = 1'b0;
         prev_x     = '0;
         prev_y     = '0;
         mismatches = 0;
      endfunction

      // Round toward minus infinity
      function longint floor_centi(longint n);
         if (n >= 0) return n / 100;
         return -((-n + 99) / 100);
      endfunction

      function longint unsigned root_floor(longint unsigned v);
         longint unsigned res;
         longint unsigned probe;
         res   = 0;
         probe = 64'd1 << 62;
         while (probe > v) probe >>= 2;
         while (probe != 0) begin
            if (v >= res + probe) begin
               v   = v - (res + probe);
               res = (res >> 1) + probe;
            end else begin
               res = res >> 1;
            end
            probe >>= 2;
         end
         return res;
      endfunction

      function logic [CoordWidth-1:0] to_mils(longint q8);
         if (q8 < 0) return '0;
         if ((q8 >>> 8) > COORD_LIMIT) return CoordWidth'(COORD_LIMIT);
         return CoordWidth'(q8 >>> 8);
      endfunction

      function void push_step(logic [BitsWidth-1:0] bits, longint hold, bit tail);
         result_type r;
         r            = '0;
         r.drive_bits = bits;
         r.wait_us    = WaitWidth'(hold);
         r.last       = tail;
         steps_due.push_back(r);
      endfunction

      function void note_dot(logic signed [19:0] tx, logic signed [19:0] ty, logic ep);
         longint               xq;
         longint               yq;
         longint               dx;
         longint               dy;
         longint unsigned      span;
         longint unsigned      settle;
         logic [BitsWidth-1:0] gas;
         logic [BitsWidth-1:0] weld;
         logic [BitsWidth-1:0] extra;
         result_type           mv;
         xq     = floor_centi((longint'(tx) + OFFSET_X_Q8) * MILS_X_CENTI);
         yq     = floor_centi((longint'(ty) + OFFSET_Y_Q8) * MILS_Y_CENTI);
         dx     = xq - longint'(prev_x);
         dy     = yq - longint'(prev_y);
         span   = root_floor(longint'(dx * dx) + longint'(dy * dy));
         settle = SETTLE_US + ((SETTLE_PER_MIL * span) >> 8);
         if (settle > HOLD_LIMIT) settle = HOLD_LIMIT;
         prev_x = 32'(xq);
         prev_y = 32'(yq);
         gas    = sim_on ? '0 : BIT_GAS;
         weld   = sim_on ? '0 : BIT_WELDER;
         extra  = ep ? BIT_EXTRA : '0;

         mv         = '0;
         mv.is_move = 1'b1;
         mv.move_x  = to_mils(xq);
         mv.move_y  = to_mils(yq);
         mv.wait_us = WaitWidth'(settle);
         steps_due.push_back(mv);
         push_step(BIT_RELEASE | gas, 400000, 1'b0);
         push_step(BIT_RELEASE | BIT_DOWN | gas | extra, 300000, 1'b0);
         push_step(BIT_RELEASE | BIT_DOWN | gas | weld | extra, 500000, 1'b0);
         push_step(BIT_RELEASE | BIT_DOWN | gas, 300000, 1'b0);
         push_step(gas, 300000, 1'b0);
         push_step('0, 3000000, 1'b1);
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (steps_due.size() == 0) begin
            $error("result transfer with no step pending");
            mismatches++;
            return;
         end
         want = steps_due.pop_front();
         if (got.is_move !== want.is_move) begin
            $error("is_move: expected %0d, got %0d", want.is_move, got.is_move);
            mismatches++;
         end
         if (got.move_x !== want.move_x) begin
            $error("move_x: expected %0d, got %0d", want.move_x, got.move_x);
            mismatches++;
         end
         if (got.move_y !== want.move_y) begin
            $error("move_y: expected %0d, got %0d", want.move_y, got.move_y);
            mismatches++;
         end
         if (got.drive_bits !== want.drive_bits) begin
            $error("drive_bits: expected %0h, got %0h", want.drive_bits, got.drive_bits);
            mismatches++;
         end
         if (got.wait_us !== want.wait_us) begin
            $error("wait_us: expected %0d, got %0d", want.wait_us, got.wait_us);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            mismatches++;
         end
      endfunction
   endclass

   dot_step_board board = new();

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int csr_errors    = 0;
   int cycles        = 0;
   int prev_tx       = 0;
   int prev_ty       = 0;

   int dir_x [DIRECTED] = '{0, 0, 524287, -65536, 524287, -65536,
                            -3968, -3969, -3967, 256, 1, -1};
   int dir_y [DIRECTED] = '{0, 0, 524287, -65536, -65536, 524287,
                            -1536, -1537, -1535, 256, 1, -1};
   bit dir_ep [DIRECTED] = '{0, 1, 1, 0, 1, 0, 1, 0, 1, 1, 0, 1};

   int phase_idle [4]  = '{0, 86, 0, 13};
   int phase_stall [4] = '{0, 0, 86, 13};

   always #(HALF_PERIOD) clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result side: check each transfer, then pick ready for the next cycle
   initial begin
      result_type got;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.is_move    = rsp_chan.is_move;
            got.move_x     = rsp_chan.move_x;
            got.move_y     = rsp_chan.move_y;
            got.drive_bits = rsp_chan.drive_bits;
            got.wait_us    = rsp_chan.wait_us;
            got.last       = rsp_chan.last;
            board.check_result(got);
         end
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic int clamp_pos(int v);
      if (v < POS_MIN) return POS_MIN;
      if (v > POS_MAX) return POS_MAX;
      return v;
   endfunction

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == ADDR_SIMULATE) board.sim_on = data[0];
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic csr_read_check(input logic [2:0] addr, input logic [31:0] want);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) begin
         $error("prdata: expected %0h, got %0h", want, prdata);
         csr_errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic send_dot(input int tx, input int ty, input bit ep);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.target_x    <= 20'(tx);
      req_chan.target_y    <= 20'(ty);
      req_chan.power_boost <= ep;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      board.note_dot(20'(tx), 20'(ty), ep);
      prev_tx = tx;
      prev_ty = ty;
   endtask

   initial begin
      int tx;
      int ty;
      bit ep;
      int roll;
      bit sim;
      reset                <= 1'b1;
      psel                 <= 1'b0;
      penable              <= 1'b0;
      pwrite               <= 1'b0;
      paddr                <= '0;
      pwdata               <= '0;
      req_chan.valid       <= 1'b0;
      req_chan.target_x    <= '0;
      req_chan.target_y    <= '0;
      req_chan.power_boost <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      csr_read_check(ADDR_SIMULATE, 32'd0);
      // Out-of-range register: the write must not reach simulate
      csr_write(ADDR_UNUSED, 32'hFFFF_FFFF);
      csr_read_check(ADDR_SIMULATE, 32'd0);

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = phase_idle[ph];
         stall_pct     = phase_stall[ph];
         sim           = ph[0];
         csr_write(ADDR_SIMULATE, {31'($urandom_range(32'h7FFF_FFFF)), sim});
         csr_read_check(ADDR_SIMULATE, {31'd0, sim});

         if (ph == 0) begin
            for (int i = 0; i < DIRECTED; i++) send_dot(dir_x[i], dir_y[i], dir_ep[i]);
         end

         for (int i = 0; i < PHASE_DOTS; i++) begin
            roll = $urandom_range(99);
            if (roll < 55) begin
               tx = int'($urandom_range(POS_SPAN)) + POS_MIN;
               ty = int'($urandom_range(POS_SPAN)) + POS_MIN;
            end else if (roll < 80) begin
               // Short hop from the last dot
               tx = clamp_pos(prev_tx + int'($urandom_range(1024)) - 512);
               ty = clamp_pos(prev_ty + int'($urandom_range(1024)) - 512);
            end else begin
               tx = $urandom_range(1) ? POS_MAX : POS_MIN;
               ty = $urandom_range(1) ? POS_MAX : POS_MIN;
            end
            ep = 1'($urandom_range(1));
            send_dot(tx, ty, ep);
         end
         req_chan.valid <= 1'b0;

         // Drain before touching the register again
         while (!(board.steps_due.size() == 0 && req_chan.ready)) @(posedge clock);
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && csr_errors == 0 && board.steps_due.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/swds_pkg.sv
hdl/swds_if.sv
hdl/swds_csr.sv
hdl/swds_dp.sv
hdl/swds_ctrl.sv
hdl/spot_weld_dot_sequencer_top.sv
bench/spot_weld_dot_sequencer_top_tb.sv
